FILE: rtl/ncr2u8_pkg.sv
package ncr2u8_pkg;

    // Code point limits and the bad ranges
    localparam int unsigned ACC_W = 25;
    localparam int unsigned CP_W  = 21;

    localparam logic [ACC_W-1:0] CP_MAX     = 25'h010_ffff;
    localparam logic [ACC_W-1:0] SURR_LO    = 25'h000_d800;
    localparam logic [ACC_W-1:0] SURR_HI    = 25'h000_dfff;
    localparam logic [ACC_W-1:0] C0_LO_END  = 25'h000_0008;
    localparam logic [ACC_W-1:0] C0_VT      = 25'h000_000b;
    localparam logic [ACC_W-1:0] C0_HI_LO   = 25'h000_000e;
    localparam logic [ACC_W-1:0] C0_HI_END  = 25'h000_001f;
    localparam logic [ACC_W-1:0] C1_LO      = 25'h000_007f;
    localparam logic [ACC_W-1:0] C1_HI      = 25'h000_009f;
    localparam logic [CP_W-1:0]  CP_REPL    = 21'h00_fffd;

    // UTF-8 lead and continuation bits
    localparam logic [7:0] LEAD2    = 8'hc0;
    localparam logic [7:0] LEAD3    = 8'he0;
    localparam logic [7:0] LEAD4    = 8'hf0;
    localparam logic [7:0] CONT     = 8'h80;
    localparam logic [5:0] CONT_MSK = 6'h3f;

    // Input beat
    typedef struct packed {
        logic [7:0] digit_char;
        logic       has_digit;
        logic       hex_mode;
        logic       last_digit;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out;

    // Encoded code point: byte 0 goes out first; nmin1 = byte count - 1
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      nmin1;
    } t_enc;

endpackage

FILE: rtl/ncr2u8_encode.sv
module ncr2u8_encode
    import ncr2u8_pkg::*;
(
    input  logic [ACC_W-1:0] i_cp,
    input  logic             i_ovf,
    input  logic             i_bad_char,
    output t_enc             o_enc
);

    logic            bad;
    logic [CP_W-1:0] cp;

    // Replace overflow, bad characters and forbidden values with U+FFFD
    always_comb begin
        bad = i_ovf || i_bad_char
            || (i_cp > CP_MAX)
            || (i_cp >= SURR_LO && i_cp <= SURR_HI)
            || (i_cp <= C0_LO_END) || (i_cp == C0_VT)
            || (i_cp >= C0_HI_LO && i_cp <= C0_HI_END)
            || (i_cp >= C1_LO && i_cp <= C1_HI);
        cp = bad ? CP_REPL : i_cp[CP_W-1:0];
    end

    // UTF-8 byte split
    always_comb begin
        o_enc = '0;
        priority if (cp < 21'h80) begin
            o_enc.bytes[0] = cp[7:0];
            o_enc.nmin1    = 2'd0;
        end else if (cp < 21'h800) begin
            o_enc.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            o_enc.bytes[1] = CONT  | {2'b00, cp[5:0] & CONT_MSK};
            o_enc.nmin1    = 2'd1;
        end else if (cp < 21'h10000) begin
            o_enc.bytes[0] = LEAD3 | {4'h0, cp[15:12]};
            o_enc.bytes[1] = CONT  | {2'b00, cp[11:6]};
            o_enc.bytes[2] = CONT  | {2'b00, cp[5:0]};
            o_enc.nmin1    = 2'd2;
        end else begin
            o_enc.bytes[0] = LEAD4 | {5'h00, cp[20:18]};
            o_enc.bytes[1] = CONT  | {2'b00, cp[17:12]};
            o_enc.bytes[2] = CONT  | {2'b00, cp[11:6]};
            o_enc.bytes[3] = CONT  | {2'b00, cp[5:0]};
            o_enc.nmin1    = 2'd3;
        end
    end

endmodule

FILE: rtl/numeric_char_ref_to_utf8_unit.sv
// Decodes one numeric character reference, one digit byte per input beat, into
// UTF-8 bytes, one per output beat with last_byte on the final one. Digit beats
// are taken every cycle while o_ready is high, and the accumulator does one
// shift-add per beat. A beat marked last_digit parks the finished code point in
// a one-entry holding register, and the output serializer encodes it and drains
// one to four bytes, one per cycle while i_ready is high. Input stalls only when
// the holding register is full and the serializer cannot take it in that cycle,
// so the sustained rate is one digit a cycle while the byte output keeps up; the
// serializer's one byte per cycle sets the limit for short references.
module numeric_char_ref_to_utf8_unit
    import ncr2u8_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    // Accumulator state
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic             r_bad, n_bad;

    // Holding register for a finished reference
    logic             r_pkt_valid;
    logic [ACC_W-1:0] r_pkt_cp;
    logic             r_pkt_ovf;
    logic             r_pkt_bad;

    // Output serializer
    logic             r_ser_valid;
    logic [3:0][7:0]  r_ser_bytes;
    logic [1:0]       r_ser_left;

    logic             in_acc;
    logic             out_acc;
    logic             ser_load;
    logic [4:0]       dval;
    logic             dok;
    logic [ACC_W-1:0] scaled;
    t_enc             enc;

    assign out_acc  = r_ser_valid && i_ready;
    assign ser_load = r_pkt_valid && (!r_ser_valid || (out_acc && r_ser_left == 2'd0));
    assign o_ready  = !r_pkt_valid || ser_load;
    assign in_acc   = i_valid && o_ready;

    // Hex digit value; dok low for any other byte
    always_comb begin
        dval = 5'd0;
        dok  = 1'b1;
        priority if (i_data.digit_char >= 8'h30 && i_data.digit_char <= 8'h39) begin
            dval = 5'(i_data.digit_char - 8'h30);
        end else if (i_data.digit_char >= 8'h61 && i_data.digit_char <= 8'h66) begin
            dval = 5'(i_data.digit_char - 8'h57);
        end else if (i_data.digit_char >= 8'h41 && i_data.digit_char <= 8'h46) begin
            dval = 5'(i_data.digit_char - 8'h37);
        end else begin
            dok  = 1'b0;
        end
    end

    // Shift-add: times sixteen, or times eight plus times two
    always_comb begin
        if (i_data.hex_mode) begin
            scaled = {r_acc[ACC_W-5:0], 4'h0};
        end else begin
            scaled = {r_acc[ACC_W-4:0], 3'b000} + {r_acc[ACC_W-2:0], 1'b0};
        end
    end

    // Next accumulator state
    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        n_bad = r_bad;
        if (i_data.has_digit) begin
            priority if (!dok) begin
                n_bad = 1'b1;
            end else if (r_acc > CP_MAX) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = scaled + {{(ACC_W-5){1'b0}}, dval};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_bad <= 1'b0;
        end else if (in_acc) begin
            if (i_data.last_digit) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
                r_bad <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_ovf <= n_ovf;
                r_bad <= n_bad;
            end
        end
    end

    // Holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_valid <= 1'b0;
        end else if (in_acc && i_data.last_digit) begin
            r_pkt_valid <= 1'b1;
        end else if (ser_load) begin
            r_pkt_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.last_digit) begin
            r_pkt_cp  <= n_acc;
            r_pkt_ovf <= n_ovf;
            r_pkt_bad <= n_bad;
        end
    end

    ncr2u8_encode u_encode (
        .i_cp       (r_pkt_cp),
        .i_ovf      (r_pkt_ovf),
        .i_bad_char (r_pkt_bad),
        .o_enc      (enc)
    );

    // Serializer: byte 0 is on the port, shift down on each beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
        end else if (ser_load) begin
            r_ser_valid <= 1'b1;
        end else if (out_acc && r_ser_left == 2'd0) begin
            r_ser_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_ser_bytes <= enc.bytes;
            r_ser_left  <= enc.nmin1;
        end else if (out_acc) begin
            r_ser_bytes <= {8'h00, r_ser_bytes[3:1]};
            r_ser_left  <= r_ser_left - 2'd1;
        end
    end

    assign o_valid          = r_ser_valid;
    assign o_data.out_byte  = r_ser_bytes[0];
    assign o_data.last_byte = (r_ser_left == 2'd0);

`ifndef SYNTHESIS
    // A final beat parks its code point for the serializer
    a_last_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.last_digit |=> r_pkt_valid)
        else $error("final beat did not reach holding register");

    // State clears after a reference ends
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.last_digit |=> (r_acc == '0) && !r_ovf && !r_bad)
        else $error("accumulator not cleared after reference");

    // Serializer empties after its last byte when nothing is waiting
    a_ser_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (r_ser_left == 2'd0) && !r_pkt_valid |=> !r_ser_valid)
        else $error("serializer kept a drained reference");

    // Accumulator never grows past one digit beyond the limit
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= 25'h10f_ffff)
        else $error("accumulator out of range");
`endif

endmodule
